@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/spt_pkg.sv @@
package spt_pkg;

   localparam int MAX_COLS    = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int MAX_ENTRIES = 4096;
   localparam int MAX_SLOTS   = 8192;

   localparam int CFG_W   = 11;
   localparam int COL_AW  = 10;
   localparam int ENT_AW  = 12;
   localparam int ROW_AW  = 11;
   localparam int SLOT_AW = 13;
   localparam int HIST_W  = 13;
   localparam int PTR_W   = 14;
   localparam int POS_W   = 27;
   localparam int PROD_W  = 24;
   localparam int SRC_W   = 10;
   localparam int VAL_W   = 64;
   localparam int IDX_W   = 13;
   localparam int ECNT_W  = 13;
   localparam int CNT_W   = 14;
   localparam int ENT_W   = 2 * SRC_W + VAL_W;
   localparam int SLOT_W  = 1 + SRC_W + VAL_W;
   localparam int RPTR_W  = 2 * PTR_W;
   localparam int LEN_SAT = 16383;

   localparam logic [2:0] FN_LOAD  = 3'd0;
   localparam logic [2:0] FN_BUILD = 3'd1;
   localparam logic [2:0] FN_RDPTR = 3'd2;
   localparam logic [2:0] FN_RDSLT = 3'd3;
   localparam logic [2:0] FN_CLEAR = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_COL_OOR  = 3'd2;
   localparam logic [2:0] ST_OVERFLOW = 3'd3;
   localparam logic [2:0] ST_BAD_READ = 3'd4;

   localparam logic REG_COL_COUNT = 1'b0;
   localparam logic REG_RATIO     = 1'b1;

   typedef struct packed {
      logic [2:0]        status;
      logic [PTR_W-1:0]  row_start;
      logic [PTR_W-1:0]  row_end;
      logic [SRC_W-1:0]  slot_row;
      logic [VAL_W-1:0]  slot_value;
      logic              slot_used;
      logic [PTR_W-1:0]  total_length;
   } rsp_type;

endpackage

@@ rtl/sparse_transpose_padded_top.sv @@
// load, row pointer read, slot read: result set in S_LD, S_RP, S_SL; rejected: in idle
// a new load or read waits for idle; the histogram and store read ports are registered
// build: HRD, HMUL, HACC for all 1024 columns; SCLR per slot; ERD, RRD, SWR per entry
// clear all: one histogram entry per cycle
// reset is synchronous; a clear of all 1024 histogram entries then holds req_ready low
`include "assert_macros.svh"

module sparse_transpose_padded_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [9:0]  req_src_row,
   input  logic [9:0]  req_src_col,
   input  logic [63:0] req_value_bits,
   input  logic [12:0] req_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [13:0] rsp_row_start,
   output logic [13:0] rsp_row_end,
   output logic [9:0]  rsp_slot_row,
   output logic [63:0] rsp_slot_value,
   output logic        rsp_slot_used,
   output logic [13:0] rsp_total_length,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LD, S_RP, S_SL, S_HRD, S_HMUL, S_HACC,
      S_BDONE, S_SCLR, S_ERD, S_RRD, S_SWR
   } state_type;

   state_type                       state_ff;
   logic [spt_pkg::CNT_W-1:0]       idx_ff;
   logic [spt_pkg::ECNT_W-1:0]      entry_count_ff;
   logic [spt_pkg::POS_W-1:0]       pos_ff;
   logic [spt_pkg::HIST_W-1:0]      w_ff;
   logic [spt_pkg::PROD_W-1:0]      prod_ff;
   logic                            beyond_ff;
   logic                            built_ff;
   logic [spt_pkg::PTR_W-1:0]       total_len_ff;
   logic [spt_pkg::CFG_W-1:0]       col_count_ff;
   logic [spt_pkg::CFG_W-1:0]       ratio_ff;
   logic                            clr_rsp_ff;
   logic [spt_pkg::COL_AW-1:0]      ld_col_ff;
   logic                            pend_ff;
   spt_pkg::rsp_type                res_ff;
   logic                            out_valid_ff;
   spt_pkg::rsp_type                out_ff;

   logic [spt_pkg::HIST_W-1:0]      hist_mem [spt_pkg::MAX_COLS];
   logic [spt_pkg::HIST_W-1:0]      hist_q_ff;
   logic                            hist_we;
   logic [spt_pkg::COL_AW-1:0]      hist_waddr, hist_raddr;
   logic [spt_pkg::HIST_W-1:0]      hist_wdata;

   logic [spt_pkg::ENT_W-1:0]       entry_mem [spt_pkg::MAX_ENTRIES];
   logic [spt_pkg::ENT_W-1:0]       entry_q_ff;
   logic                            entry_we;
   logic [spt_pkg::ENT_AW-1:0]      entry_waddr, entry_raddr;
   logic [spt_pkg::ENT_W-1:0]       entry_wdata;

   logic [spt_pkg::RPTR_W-1:0]      row_mem [spt_pkg::MAX_COLS+1];
   logic [spt_pkg::RPTR_W-1:0]      row_q_ff;
   logic                            row_we;
   logic [spt_pkg::ROW_AW-1:0]      row_waddr, row_raddr;
   logic [spt_pkg::RPTR_W-1:0]      row_wdata;

   logic [spt_pkg::SLOT_W-1:0]      slot_mem [spt_pkg::MAX_SLOTS];
   logic [spt_pkg::SLOT_W-1:0]      slot_q_ff;
   logic                            slot_we;
   logic [spt_pkg::SLOT_AW-1:0]     slot_waddr, slot_raddr;
   logic [spt_pkg::SLOT_W-1:0]      slot_wdata;

   logic [spt_pkg::CFG_W-1:0]       eff_cols;
   logic                            accept, out_free, xfer, ld_ok, csr_wr;
   logic [spt_pkg::SRC_W-1:0]       e_col, e_row;
   logic [spt_pkg::VAL_W-1:0]       e_val;
   logic [spt_pkg::PTR_W-1:0]       r_start, r_end;
   logic                            e_fits;

   always_comb begin
      if (col_count_ff == '0) begin
         eff_cols = spt_pkg::CFG_W'(1);
      end else if (col_count_ff > spt_pkg::CFG_W'(spt_pkg::MAX_COLS)) begin
         eff_cols = spt_pkg::CFG_W'(spt_pkg::MAX_COLS);
      end else begin
         eff_cols = col_count_ff;
      end
   end

   assign out_free  = !out_valid_ff || rsp_ready;
   assign xfer      = pend_ff && out_free;
   assign req_ready = (state_ff == S_IDLE) && (!pend_ff || out_free);
   assign accept    = req_valid && req_ready;
   assign ld_ok     = (entry_count_ff < spt_pkg::ECNT_W'(spt_pkg::MAX_ENTRIES))
                      && ({1'b0, req_src_col} < eff_cols);
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == spt_pkg::REG_RATIO)
                       ? 32'(ratio_ff) : 32'(col_count_ff);

   assign e_col   = entry_q_ff[spt_pkg::ENT_W-1 -: spt_pkg::SRC_W];
   assign e_row   = entry_q_ff[spt_pkg::VAL_W +: spt_pkg::SRC_W];
   assign e_val   = entry_q_ff[spt_pkg::VAL_W-1:0];
   assign r_start = row_q_ff[spt_pkg::RPTR_W-1 -: spt_pkg::PTR_W];
   assign r_end   = row_q_ff[spt_pkg::PTR_W-1:0];
   assign e_fits  = ({1'b0, e_col} < eff_cols)
                    && (r_end < spt_pkg::PTR_W'(spt_pkg::MAX_SLOTS));

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_row_start    = out_ff.row_start;
   assign rsp_row_end      = out_ff.row_end;
   assign rsp_slot_row     = out_ff.slot_row;
   assign rsp_slot_value   = out_ff.slot_value;
   assign rsp_slot_used    = out_ff.slot_used;
   assign rsp_total_length = out_ff.total_length;

   // memory port control
   always_comb begin
      hist_we     = 1'b0;
      hist_waddr  = ld_col_ff;
      hist_wdata  = hist_q_ff + spt_pkg::HIST_W'(1);
      hist_raddr  = (state_ff == S_IDLE) ? req_src_col : idx_ff[spt_pkg::COL_AW-1:0];
      entry_we    = accept && (req_func == spt_pkg::FN_LOAD) && ld_ok;
      entry_waddr = entry_count_ff[spt_pkg::ENT_AW-1:0];
      entry_wdata = {req_src_col, req_src_row, req_value_bits};
      entry_raddr = idx_ff[spt_pkg::ENT_AW-1:0];
      row_we      = 1'b0;
      row_waddr   = idx_ff[spt_pkg::ROW_AW-1:0];
      row_wdata   = {pos_ff[spt_pkg::PTR_W-1:0], pos_ff[spt_pkg::PTR_W-1:0]};
      row_raddr   = (state_ff == S_IDLE) ? req_index[spt_pkg::ROW_AW-1:0] : {1'b0, e_col};
      slot_we     = 1'b0;
      slot_waddr  = idx_ff[spt_pkg::SLOT_AW-1:0];
      slot_wdata  = '0;
      slot_raddr  = req_index;
      unique case (state_ff)
         S_LD: begin
            hist_we = 1'b1;
         end
         S_CLEAR: begin
            hist_we    = 1'b1;
            hist_waddr = idx_ff[spt_pkg::COL_AW-1:0];
            hist_wdata = '0;
         end
         S_HACC: begin
            row_we = (idx_ff < spt_pkg::CNT_W'(eff_cols));
         end
         S_BDONE: begin
            row_we    = !beyond_ff && (pos_ff <= spt_pkg::POS_W'(spt_pkg::MAX_SLOTS));
            row_waddr = eff_cols;
         end
         S_SCLR: begin
            slot_we = 1'b1;
         end
         S_SWR: begin
            row_we     = e_fits;
            row_waddr  = {1'b0, e_col};
            row_wdata  = {r_start, r_end + spt_pkg::PTR_W'(1)};
            slot_we    = e_fits;
            slot_waddr = r_end[spt_pkg::SLOT_AW-1:0];
            slot_wdata = {1'b1, e_row, e_val};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      hist_q_ff <= hist_mem[hist_raddr];
   end

   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_waddr] <= entry_wdata;
      end
      entry_q_ff <= entry_mem[entry_raddr];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      row_q_ff <= row_mem[row_raddr];
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_q_ff <= slot_mem[slot_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         idx_ff         <= '0;
         entry_count_ff <= '0;
         pos_ff         <= '0;
         beyond_ff      <= 1'b0;
         built_ff       <= 1'b0;
         total_len_ff   <= '0;
         col_count_ff   <= spt_pkg::CFG_W'(1);
         ratio_ff       <= '0;
         clr_rsp_ff     <= 1'b0;
         pend_ff        <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (xfer) begin
            out_ff       <= res_ff;
            out_valid_ff <= 1'b1;
            pend_ff      <= 1'b0;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               idx_ff <= idx_ff + spt_pkg::CNT_W'(1);
               if (idx_ff == spt_pkg::CNT_W'(spt_pkg::MAX_COLS - 1)) begin
                  state_ff <= S_IDLE;
                  if (clr_rsp_ff) begin
                     res_ff  <= '0;
                     pend_ff <= 1'b1;
                  end
               end
            end
            S_IDLE: begin
               if (accept) begin
                  res_ff <= '0;
                  unique case (req_func)
                     spt_pkg::FN_LOAD: begin
                        if (entry_count_ff >= spt_pkg::ECNT_W'(spt_pkg::MAX_ENTRIES)) begin
                           res_ff.status <= spt_pkg::ST_FULL;
                           pend_ff       <= 1'b1;
                        end else if (!ld_ok) begin
                           res_ff.status <= spt_pkg::ST_COL_OOR;
                           pend_ff       <= 1'b1;
                        end else begin
                           entry_count_ff <= entry_count_ff + spt_pkg::ECNT_W'(1);
                           built_ff       <= 1'b0;
                           ld_col_ff      <= req_src_col;
                           state_ff       <= S_LD;
                        end
                     end
                     spt_pkg::FN_BUILD: begin
                        idx_ff    <= '0;
                        pos_ff    <= '0;
                        beyond_ff <= 1'b0;
                        built_ff  <= 1'b0;
                        state_ff  <= S_HRD;
                     end
                     spt_pkg::FN_RDPTR: begin
                        if (!built_ff || ({1'b0, req_index} > spt_pkg::CNT_W'(eff_cols))) begin
                           res_ff.status <= spt_pkg::ST_BAD_READ;
                           pend_ff       <= 1'b1;
                        end else begin
                           state_ff <= S_RP;
                        end
                     end
                     spt_pkg::FN_RDSLT: begin
                        if (!built_ff || ({1'b0, req_index} >= total_len_ff)) begin
                           res_ff.status <= spt_pkg::ST_BAD_READ;
                           pend_ff       <= 1'b1;
                        end else begin
                           state_ff <= S_SL;
                        end
                     end
                     spt_pkg::FN_CLEAR: begin
                        entry_count_ff <= '0;
                        built_ff       <= 1'b0;
                        total_len_ff   <= '0;
                        idx_ff         <= '0;
                        clr_rsp_ff     <= 1'b1;
                        state_ff       <= S_CLEAR;
                     end
                     default: begin
                        res_ff.status <= spt_pkg::ST_BAD_READ;
                        pend_ff       <= 1'b1;
                     end
                  endcase
               end
            end
            S_LD: begin
               res_ff   <= '0;
               pend_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_RP: begin
               res_ff              <= '0;
               res_ff.row_start    <= r_start;
               res_ff.row_end      <= r_end;
               res_ff.total_length <= total_len_ff;
               pend_ff             <= 1'b1;
               state_ff            <= S_IDLE;
            end
            S_SL: begin
               res_ff              <= '0;
               res_ff.total_length <= total_len_ff;
               if (slot_q_ff[spt_pkg::SLOT_W-1]) begin
                  res_ff.slot_row   <= slot_q_ff[spt_pkg::VAL_W +: spt_pkg::SRC_W];
                  res_ff.slot_value <= slot_q_ff[spt_pkg::VAL_W-1:0];
                  res_ff.slot_used  <= 1'b1;
               end
               pend_ff  <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_HRD: begin
               state_ff <= S_HMUL;
            end
            S_HMUL: begin
               w_ff    <= hist_q_ff;
               prod_ff <= spt_pkg::PROD_W'(hist_q_ff) * spt_pkg::PROD_W'(ratio_ff);
               if ((idx_ff >= spt_pkg::CNT_W'(eff_cols)) && (hist_q_ff != '0)) begin
                  beyond_ff <= 1'b1;
               end
               state_ff <= S_HACC;
            end
            S_HACC: begin
               if (idx_ff < spt_pkg::CNT_W'(eff_cols)) begin
                  pos_ff <= pos_ff + spt_pkg::POS_W'(w_ff)
                            + spt_pkg::POS_W'(prod_ff[spt_pkg::PROD_W-1:8]);
               end
               if (idx_ff == spt_pkg::CNT_W'(spt_pkg::MAX_COLS - 1)) begin
                  state_ff <= S_BDONE;
               end else begin
                  idx_ff   <= idx_ff + spt_pkg::CNT_W'(1);
                  state_ff <= S_HRD;
               end
            end
            S_BDONE: begin
               res_ff <= '0;
               idx_ff <= '0;
               if (beyond_ff) begin
                  res_ff.status <= spt_pkg::ST_COL_OOR;
                  pend_ff       <= 1'b1;
                  state_ff      <= S_IDLE;
               end else if (pos_ff > spt_pkg::POS_W'(spt_pkg::MAX_SLOTS)) begin
                  res_ff.status <= spt_pkg::ST_OVERFLOW;
                  res_ff.total_length <= (pos_ff > spt_pkg::POS_W'(spt_pkg::LEN_SAT))
                                         ? spt_pkg::PTR_W'(spt_pkg::LEN_SAT)
                                         : pos_ff[spt_pkg::PTR_W-1:0];
                  pend_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else if (pos_ff == '0) begin
                  built_ff     <= 1'b1;
                  total_len_ff <= '0;
                  pend_ff      <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_SCLR;
               end
            end
            S_SCLR: begin
               if (spt_pkg::POS_W'(idx_ff) == pos_ff - spt_pkg::POS_W'(1)) begin
                  idx_ff   <= '0;
                  state_ff <= S_ERD;
               end else begin
                  idx_ff <= idx_ff + spt_pkg::CNT_W'(1);
               end
            end
            S_ERD: begin
               state_ff <= S_RRD;
            end
            S_RRD: begin
               state_ff <= S_SWR;
            end
            S_SWR: begin
               if (idx_ff + spt_pkg::CNT_W'(1) >= spt_pkg::CNT_W'(entry_count_ff)) begin
                  res_ff              <= '0;
                  res_ff.total_length <= pos_ff[spt_pkg::PTR_W-1:0];
                  built_ff            <= 1'b1;
                  total_len_ff        <= pos_ff[spt_pkg::PTR_W-1:0];
                  pend_ff             <= 1'b1;
                  state_ff            <= S_IDLE;
               end else begin
                  idx_ff   <= idx_ff + spt_pkg::CNT_W'(1);
                  state_ff <= S_ERD;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (csr_wr) begin
            if (csr_paddr[2] == spt_pkg::REG_RATIO) begin
               ratio_ff <= csr_pwdata[spt_pkg::CFG_W-1:0];
            end else begin
               col_count_ff <= csr_pwdata[spt_pkg::CFG_W-1:0];
            end
            built_ff <= 1'b0;
         end
      end
   end

   `ASSERT_ALWAYS(a_pend_only_idle, clock, reset, !pend_ff || (state_ff == S_IDLE))
   `ASSERT_ALWAYS(a_built_fits, clock, reset,
      !built_ff || (total_len_ff <= spt_pkg::PTR_W'(spt_pkg::MAX_SLOTS)))
   `ASSERT_NEXT(a_load_counts, clock, reset,
      accept && (req_func == spt_pkg::FN_LOAD) && ld_ok,
      entry_count_ff == $past(entry_count_ff) + spt_pkg::ECNT_W'(1))
   `ASSERT_NEXT(a_busy_no_ready, clock, reset,
      accept && (req_func == spt_pkg::FN_BUILD), !req_ready)

endmodule
